[hw/rtl/ocu_pkg.sv]
package ocu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_CORDIC_INIT,
        ST_CORDIC_RUN,
        ST_MUL,
        ST_POST,
        ST_VEC,
        ST_OUT
    } state_t;

    // micro-ops of the shared multiplier, in issue order
    typedef enum logic [4:0] {
        OP_SPST, OP_SPCT, OP_CPST, OP_CPCT,
        OP_SPEED,
        OP_RDX0, OP_UDY0, OP_RDX1, OP_UDY1, OP_RDX2, OP_UDY2,
        OP_PAN0, OP_PAN1, OP_PAN2,
        OP_EYE0, OP_EYE1, OP_EYE2
    } op_t;

    localparam logic [2:0] CMD_ROTATE   = 3'd0;
    localparam logic [2:0] CMD_PAN      = 3'd1;
    localparam logic [2:0] CMD_ZOOM     = 3'd2;
    localparam logic [2:0] CMD_SET_DIST = 3'd3;
    localparam logic [2:0] CMD_SET_TGT  = 3'd4;

    localparam logic [1:0] CFG_MIN_DISTANCE = 2'd0;
    localparam logic [1:0] CFG_PAN_GAIN     = 2'd1;
    localparam logic [1:0] CFG_ELEV_MARGIN  = 2'd2;

    localparam int ANG_PI      = 12868;
    localparam int ANG_TWO_PI  = 25736;
    localparam int ANG_HALF_PI = 6434;
    localparam int CORDIC_GAIN = 652032874;
    localparam int UNIT_Q14    = 16384;

    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IW    = 5;

    localparam logic signed [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128
    };

    // Q2.30 -> Q1.14, round half up, clamp to +-1.0
    function automatic logic signed [15:0] q14(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd32768) >>> 16;
        if (r > 34'(UNIT_Q14)) begin
            return 16'(UNIT_Q14);
        end else if (r < -34'(UNIT_Q14)) begin
            return -16'(UNIT_Q14);
        end
        return r[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -49'sh80000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[hw/rtl/orbit_camera_update_top.sv]
// Orbit camera: one command beat in, one pose beat out.
// CORDIC_ITERATIONS sets the CORDIC steps per angle, capped at 24; pan takes longer than
// the other commands, since it runs extra multiplier ops.
// Throughput: one item at a time; the sequencer owns one CORDIC and one
// 33x33 multiplier, and s_ready is high only when the sequencer is idle.
// Reset (aresetn low, synchronous): pose returns to azimuth 0, elevation 45 deg,
// radius 5.0, target origin; registers to their defaults; no result pending.
module orbit_camera_update_top #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // command channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_command,
    input  logic signed [15:0]  s_delta_theta,
    input  logic signed [15:0]  s_delta_phi,
    input  logic signed [15:0]  s_pan_dx,
    input  logic signed [15:0]  s_pan_dy,
    input  logic signed [31:0]  s_zoom_amount,
    input  logic signed [31:0]  s_new_distance,
    input  logic signed [31:0]  s_target_x,
    input  logic signed [31:0]  s_target_y,
    input  logic signed [31:0]  s_target_z,
    // pose channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_eye_x,
    output logic signed [31:0]  m_eye_y,
    output logic signed [31:0]  m_eye_z,
    output logic signed [15:0]  m_forward_x,
    output logic signed [15:0]  m_forward_y,
    output logic signed [15:0]  m_forward_z,
    output logic signed [15:0]  m_right_x,
    output logic signed [15:0]  m_right_y,
    output logic signed [15:0]  m_right_z,
    output logic signed [15:0]  m_up_x,
    output logic signed [15:0]  m_up_y,
    output logic signed [15:0]  m_up_z
);
    import ocu_pkg::*;

    localparam int CORDIC_N = (CORDIC_ITERATIONS > ATAN_DEPTH) ? ATAN_DEPTH
                                                                 : CORDIC_ITERATIONS;
    localparam logic [ATAN_IW-1:0] ITER_LAST = ATAN_IW'(CORDIC_N - 1);

    // control
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [ATAN_IW-1:0] iter_reg;
    logic   sel_el_reg;             // CORDIC pass: 0 azimuth, 1 elevation
    logic   m_valid_reg;

    // latched command beat
    logic [2:0]         cmd_reg;
    logic signed [15:0] dtheta_reg, dphi_reg, dx_reg, dy_reg;
    logic signed [31:0] zoom_reg, newdist_reg;
    logic signed [31:0] tin_reg [3];

    // architectural state and config
    logic [15:0]        az_reg, el_reg;
    logic signed [31:0] radius_reg;
    logic signed [31:0] target_reg [3];
    logic [30:0]        min_dist_reg;
    logic [15:0]        pan_gain_reg;
    logic [10:0]        margin_reg;

    // CORDIC
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               neg_cos_reg;
    logic signed [31:0] st_reg, ct_reg, sp_reg, cp_reg;

    // basis / pan / eye working registers
    logic signed [31:0] dir_reg [3];    // unit offset target->eye, Q2.30
    logic signed [31:0] e0_reg, e2_reg; // cos el * sin/cos az, Q2.30
    logic signed [15:0] fwd_reg [3], rgt_reg [3], up_reg [3];
    logic signed [31:0] speed_reg, acc_reg;
    logic signed [31:0] s_reg [3];
    logic signed [31:0] eye_reg [3];

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    // output registers
    logic signed [31:0] out_eye_reg [3];
    logic signed [15:0] out_fwd_reg [3], out_rgt_reg [3], out_up_reg [3];

    // combinational helpers
    logic               accept;
    logic signed [17:0] rot_a, rot_e, rot_lo, rot_hi, rot_a_mod, rot_e_cl;
    logic signed [33:0] zoom_v, dist_v, min_v;
    logic signed [17:0] ang, ang_red;
    logic               ang_neg;
    logic signed [33:0] cx_sh, cy_sh, catan;
    logic signed [65:0] rnd30, rnd20, rnd18;
    logic [1:0]         k_idx;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------- command arithmetic ----------------
    always_comb begin
        rot_a = $signed({2'b00, az_reg}) + 18'(dtheta_reg);
        // floor mod 2pi over the reachable range
        if (rot_a < -18'(ANG_TWO_PI)) begin
            rot_a_mod = rot_a + 18'(2 * ANG_TWO_PI);
        end else if (rot_a < 18'sd0) begin
            rot_a_mod = rot_a + 18'(ANG_TWO_PI);
        end else if (rot_a >= 18'(2 * ANG_TWO_PI)) begin
            rot_a_mod = rot_a - 18'(2 * ANG_TWO_PI);
        end else if (rot_a >= 18'(ANG_TWO_PI)) begin
            rot_a_mod = rot_a - 18'(ANG_TWO_PI);
        end else begin
            rot_a_mod = rot_a;
        end
        rot_e  = $signed({2'b00, el_reg}) - 18'(dphi_reg);
        rot_lo = $signed({7'd0, margin_reg});
        rot_hi = 18'(ANG_PI) - rot_lo;
        rot_e_cl = rot_e;
        if (rot_e_cl < rot_lo) begin
            rot_e_cl = rot_lo;
        end
        if (rot_e_cl > rot_hi) begin
            rot_e_cl = rot_hi;
        end
        min_v  = $signed({3'b000, min_dist_reg});
        zoom_v = 34'(radius_reg) - 34'(zoom_reg);
        if (zoom_v < min_v) begin
            zoom_v = min_v;
        end
        if (zoom_v > 34'sh7FFFFFFF) begin
            zoom_v = 34'sh7FFFFFFF;
        end
        dist_v = 34'(newdist_reg);
        if (dist_v < min_v) begin
            dist_v = min_v;
        end
    end

    // ---------------- CORDIC angle reduction and step ----------------
    always_comb begin
        ang = sel_el_reg ? $signed({2'b00, el_reg}) : $signed({2'b00, az_reg});
        if (ang >= 18'(ANG_PI)) begin
            ang = ang - 18'(ANG_TWO_PI);
        end
        ang_neg = 1'b0;
        ang_red = ang;
        if (ang > 18'(ANG_HALF_PI)) begin
            ang_red = 18'(ANG_PI) - ang;
            ang_neg = 1'b1;
        end else if (ang < -18'(ANG_HALF_PI)) begin
            ang_red = -18'(ANG_PI) - ang;
            ang_neg = 1'b1;
        end
        cx_sh = x_reg >>> iter_reg;
        cy_sh = y_reg >>> iter_reg;
        catan = 34'(ATAN_Q30[iter_reg]);
    end

    // ---------------- multiplier operand select ----------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        k_idx = '0;
        unique case (op_reg)
            OP_SPST:  begin mul_a = 33'(sp_reg);     mul_b = 33'(st_reg); end
            OP_SPCT:  begin mul_a = 33'(sp_reg);     mul_b = 33'(ct_reg); end
            OP_CPST:  begin mul_a = 33'(cp_reg);     mul_b = 33'(st_reg); end
            OP_CPCT:  begin mul_a = 33'(cp_reg);     mul_b = 33'(ct_reg); end
            OP_SPEED: begin
                mul_a = 33'(radius_reg);
                mul_b = $signed({17'd0, pan_gain_reg});
            end
            OP_RDX0:  begin mul_a = -33'(rgt_reg[0]); mul_b = 33'(dx_reg); end
            OP_UDY0:  begin mul_a = 33'(up_reg[0]);   mul_b = 33'(dy_reg); end
            OP_RDX1:  begin mul_a = -33'(rgt_reg[1]); mul_b = 33'(dx_reg); end
            OP_UDY1:  begin mul_a = 33'(up_reg[1]);   mul_b = 33'(dy_reg); end
            OP_RDX2:  begin mul_a = -33'(rgt_reg[2]); mul_b = 33'(dx_reg); end
            OP_UDY2:  begin mul_a = 33'(up_reg[2]);   mul_b = 33'(dy_reg); end
            OP_PAN0:  begin mul_a = 33'(s_reg[0]);    mul_b = 33'(speed_reg); end
            OP_PAN1:  begin mul_a = 33'(s_reg[1]);    mul_b = 33'(speed_reg); end
            OP_PAN2:  begin mul_a = 33'(s_reg[2]);    mul_b = 33'(speed_reg); end
            OP_EYE0:  begin mul_a = 33'(radius_reg);  mul_b = 33'(dir_reg[0]); end
            OP_EYE1:  begin mul_a = 33'(radius_reg);  mul_b = 33'(dir_reg[1]); end
            OP_EYE2:  begin mul_a = 33'(radius_reg);  mul_b = 33'(dir_reg[2]); end
            default:  begin mul_a = '0;               mul_b = '0; end
        endcase
        // axis of the pan / eye op in post
        if (op_reg == OP_PAN1 || op_reg == OP_EYE1) begin
            k_idx = 2'd1;
        end else if (op_reg == OP_PAN2 || op_reg == OP_EYE2) begin
            k_idx = 2'd2;
        end
        rnd30 = (prod_reg + (66'sd1 <<< 29)) >>> 30;
        rnd20 = (prod_reg + (66'sd1 <<< 19)) >>> 20;
        rnd18 = (prod_reg + (66'sd1 <<< 17)) >>> 18;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_SPST;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD:         state_next = ST_CORDIC_INIT;
            ST_CORDIC_INIT: state_next = ST_CORDIC_RUN;
            ST_CORDIC_RUN: begin
                if (iter_reg == ITER_LAST) begin
                    if (sel_el_reg) begin
                        state_next = ST_MUL;
                        op_next    = OP_SPST;
                    end else begin
                        state_next = ST_CORDIC_INIT;
                    end
                end
            end
            ST_MUL:         state_next = ST_POST;
            ST_POST: begin
                priority case (op_reg)
                    OP_CPCT:  state_next = ST_VEC;
                    OP_PAN2: begin
                        state_next = ST_MUL;
                        op_next    = OP_EYE0;
                    end
                    OP_EYE2:  state_next = ST_OUT;
                    default: begin
                        state_next = ST_MUL;
                        op_next    = op_t'(op_reg + 5'd1);
                    end
                endcase
            end
            ST_VEC: begin
                state_next = ST_MUL;
                // pan uses the basis of the pose before it; the angles don't move
                op_next    = (cmd_reg == CMD_PAN) ? OP_SPEED : OP_EYE0;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_reg        <= '0;
            el_reg        <= 16'd3217;
            radius_reg    <= 32'sd327680;
            target_reg[0] <= '0;
            target_reg[1] <= '0;
            target_reg[2] <= '0;
            min_dist_reg  <= 31'd6554;
            pan_gain_reg  <= 16'd1049;
            margin_reg    <= 11'd4;
            m_valid_reg   <= 1'b0;
            iter_reg      <= '0;
            sel_el_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_MIN_DISTANCE: min_dist_reg <= cfg_data[30:0];
                    CFG_PAN_GAIN:     pan_gain_reg <= cfg_data[15:0];
                    CFG_ELEV_MARGIN:  margin_reg   <= cfg_data[10:0];
                    default:          ;
                endcase
            end

            // in ST_OUT the reload below owns the valid flag
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg     <= s_command;
                        dtheta_reg  <= s_delta_theta;
                        dphi_reg    <= s_delta_phi;
                        dx_reg      <= s_pan_dx;
                        dy_reg      <= s_pan_dy;
                        zoom_reg    <= s_zoom_amount;
                        newdist_reg <= s_new_distance;
                        tin_reg[0]  <= s_target_x;
                        tin_reg[1]  <= s_target_y;
                        tin_reg[2]  <= s_target_z;
                    end
                end
                ST_CMD: begin
                    sel_el_reg <= 1'b0;
                    unique case (cmd_reg)
                        CMD_ROTATE: begin
                            az_reg <= rot_a_mod[15:0];
                            el_reg <= rot_e_cl[15:0];
                        end
                        CMD_ZOOM:     radius_reg <= zoom_v[31:0];
                        CMD_SET_DIST: radius_reg <= dist_v[31:0];
                        CMD_SET_TGT: begin
                            target_reg[0] <= tin_reg[0];
                            target_reg[1] <= tin_reg[1];
                            target_reg[2] <= tin_reg[2];
                        end
                        default: ;  // pan runs later, unknown codes leave state alone
                    endcase
                end
                ST_CORDIC_INIT: begin
                    x_reg       <= 34'(CORDIC_GAIN);
                    y_reg       <= '0;
                    z_reg       <= 34'(ang_red) <<< 18;
                    neg_cos_reg <= ang_neg;
                    iter_reg    <= '0;
                end
                ST_CORDIC_RUN: begin
                    if (z_reg >= 34'sd0) begin
                        x_reg <= x_reg - cy_sh;
                        y_reg <= y_reg + cx_sh;
                        z_reg <= z_reg - catan;
                    end else begin
                        x_reg <= x_reg + cy_sh;
                        y_reg <= y_reg - cx_sh;
                        z_reg <= z_reg + catan;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST) begin
                        sel_el_reg <= 1'b1;
                        // last step result, taken from the values about to land
                        if (sel_el_reg) begin
                            sp_reg <= (z_reg >= 34'sd0) ? 32'(y_reg + cx_sh)
                                                        : 32'(y_reg - cx_sh);
                            cp_reg <= (z_reg >= 34'sd0) ?
                                      (neg_cos_reg ? 32'(cy_sh - x_reg) : 32'(x_reg - cy_sh)) :
                                      (neg_cos_reg ? 32'(-x_reg - cy_sh) : 32'(x_reg + cy_sh));
                        end else begin
                            st_reg <= (z_reg >= 34'sd0) ? 32'(y_reg + cx_sh)
                                                        : 32'(y_reg - cx_sh);
                            ct_reg <= (z_reg >= 34'sd0) ?
                                      (neg_cos_reg ? 32'(cy_sh - x_reg) : 32'(x_reg - cy_sh)) :
                                      (neg_cos_reg ? 32'(-x_reg - cy_sh) : 32'(x_reg + cy_sh));
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg <= 66'(mul_a) * 66'(mul_b);
                end
                ST_POST: begin
                    unique case (op_reg)
                        OP_SPST:  dir_reg[0] <= rnd30[31:0];
                        OP_SPCT:  dir_reg[2] <= rnd30[31:0];
                        OP_CPST:  e0_reg     <= rnd30[31:0];
                        OP_CPCT:  e2_reg     <= rnd30[31:0];
                        OP_SPEED: speed_reg  <= rnd20[31:0];
                        OP_RDX0, OP_RDX1, OP_RDX2: acc_reg <= prod_reg[31:0];
                        OP_UDY0:  s_reg[0]   <= acc_reg + prod_reg[31:0];
                        OP_UDY1:  s_reg[1]   <= acc_reg + prod_reg[31:0];
                        OP_UDY2:  s_reg[2]   <= acc_reg + prod_reg[31:0];
                        OP_PAN0, OP_PAN1, OP_PAN2: begin
                            target_reg[k_idx[1:0]] <= sat32(49'(target_reg[k_idx[1:0]])
                                                            + 49'($signed(rnd18[47:0])));
                        end
                        OP_EYE0, OP_EYE1, OP_EYE2: begin
                            eye_reg[k_idx[1:0]] <= sat32(49'(target_reg[k_idx[1:0]])
                                                         + 49'($signed(rnd30[32:0])));
                        end
                        default: ;
                    endcase
                end
                ST_VEC: begin
                    dir_reg[1] <= cp_reg;
                    fwd_reg[0] <= q14(-34'(dir_reg[0]));
                    fwd_reg[1] <= q14(-34'(cp_reg));
                    fwd_reg[2] <= q14(-34'(dir_reg[2]));
                    rgt_reg[0] <= q14(34'(ct_reg));
                    rgt_reg[1] <= '0;
                    rgt_reg[2] <= q14(-34'(st_reg));
                    up_reg[0]  <= q14(-34'(e0_reg));
                    up_reg[1]  <= q14(34'(sp_reg));
                    up_reg[2]  <= q14(-34'(e2_reg));
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        out_eye_reg <= eye_reg;
                        out_fwd_reg <= fwd_reg;
                        out_rgt_reg <= rgt_reg;
                        out_up_reg  <= up_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_eye_x     = out_eye_reg[0];
    assign m_eye_y     = out_eye_reg[1];
    assign m_eye_z     = out_eye_reg[2];
    assign m_forward_x = out_fwd_reg[0];
    assign m_forward_y = out_fwd_reg[1];
    assign m_forward_z = out_fwd_reg[2];
    assign m_right_x   = out_rgt_reg[0];
    assign m_right_y   = out_rgt_reg[1];
    assign m_right_z   = out_rgt_reg[2];
    assign m_up_x      = out_up_reg[0];
    assign m_up_y      = out_up_reg[1];
    assign m_up_z      = out_up_reg[2];

endmodule

[hw/rtl/ocu_checker.sv]
module ocu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [31:0]  m_eye_x,
    input logic signed [15:0]  m_forward_x,
    input logic signed [15:0]  m_right_y
);

    // right vector lies in the horizontal plane
    a_right_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_right_y == 16'sd0))
        else $error("right_y nonzero");

    a_fwd_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_forward_x <= 16'sd16384 && m_forward_x >= -16'sd16384))
        else $error("forward_x out of unit range");

    // one item in flight: in the cycle after a beat, busy and no new result
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !$rose(m_valid)))
        else $error("accepted beat did not occupy sequencer");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_eye_x)))
        else $error("pending result dropped or changed");

endmodule

bind orbit_camera_update_top ocu_checker u_ocu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_eye_x     (m_eye_x),
    .m_forward_x (m_forward_x),
    .m_right_y   (m_right_y)
);
